@@ hdl/apu_fs_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// APU frame sequencer package
// Shared types, register index codes and widths of the frame sequencer.
// ----------------------------------------------------------------------------
package apu_fs_pkg;

  // Configuration register indexes.
  localparam int unsigned CfgIdxWidth = 3;
  localparam int unsigned CfgDataWidth = 4;

  typedef enum logic [CfgIdxWidth-1:0] {
    CFG_ENV1_PERIOD  = 3'd0,
    CFG_ENV2_PERIOD  = 3'd1,
    CFG_ENV4_PERIOD  = 3'd2,
    CFG_ENV_UP_MASK  = 3'd3,
    CFG_SWEEP_SHIFT  = 3'd4,
    CFG_SWEEP_PERIOD = 3'd5,
    CFG_SWEEP_UP     = 3'd6,
    CFG_LEN_ENABLE   = 3'd7
  } cfg_idx_e;

  // Divider bits that clock the three units.
  localparam logic [3:0] EnvDivBit = 4'd15;
  localparam logic [3:0] SweepDivBit = 4'd14;
  localparam logic [3:0] LengthDivBit = 4'd13;

  // Item kinds.
  localparam logic ActionEvent = 1'b0;
  localparam logic ActionLoad = 1'b1;

  // Channel codes on the channel field.
  localparam logic [1:0] ChanOne = 2'd0;
  localparam logic [1:0] ChanTwo = 2'd1;
  localparam logic [1:0] ChanThree = 2'd2;
  localparam logic [1:0] ChanFour = 2'd3;

  localparam logic [3:0] VolMax = 4'hF;

  // Control of one envelope slot for the item being committed.
  typedef struct packed {
    logic step;   // envelope tick
    logic load;   // channel restart
    logic up;     // volume increases
    logic on;     // channel is currently on
  } env_ctrl_t;

  // Control of the channel 1 sweep for the item being committed.
  typedef struct packed {
    logic step;   // sweep tick
    logic load;   // channel 1 restart
    logic up;     // frequency increases
    logic on;     // channel 1 still on after the envelope step
  } sweep_ctrl_t;

endpackage
`default_nettype wire

@@ hdl/apu_fs_env.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// APU frame sequencer envelope slot
// Volume and step counter of one channel envelope, with restart and step.
// ----------------------------------------------------------------------------
module apu_fs_env (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  apu_fs_pkg::env_ctrl_t ctrl_i,
  input  wire  [2:0]           period_i,
  input  wire  [3:0]           load_volume_i,
  output logic [3:0]           volume_o,
  output logic                 off_o
);

  logic [3:0] vol_q, vol_d;
  logic [2:0] cnt_q, cnt_d;
  logic [2:0] cnt_inc;
  logic       active;
  logic       fire;

  // The counter runs only while the channel is on and the period is nonzero.
  assign cnt_inc = cnt_q + 3'd1;
  assign active = ctrl_i.step & ctrl_i.on & (period_i != 3'd0);
  assign fire = active & (cnt_inc >= period_i);

  // Next volume and counter.
  always_comb begin
    vol_d = vol_q;
    cnt_d = cnt_q;
    off_o = 1'b0;
    if (ctrl_i.load) begin
      vol_d = load_volume_i;
      cnt_d = 3'd0;
    end else if (active) begin
      cnt_d = fire ? 3'd0 : cnt_inc;
      if (fire) begin
        if (ctrl_i.up) begin
          if (vol_q != apu_fs_pkg::VolMax) begin
            vol_d = vol_q + 4'd1;
          end
        end else begin
          if (vol_q != 4'd0) begin
            vol_d = vol_q - 4'd1;
          end
          // A falling envelope that sits at zero silences the channel.
          off_o = (vol_d == 4'd0);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vol_q <= 4'd0;
      cnt_q <= 3'd0;
    end else begin
      vol_q <= vol_d;
      cnt_q <= cnt_d;
    end
  end

  assign volume_o = vol_q;

endmodule
`default_nettype wire

@@ hdl/apu_fs_sweep.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// APU frame sequencer sweep unit
// Channel 1 frequency register and sweep period counter.
// ----------------------------------------------------------------------------
module apu_fs_sweep (
  input  wire                    clk_i,
  input  wire                    rst_ni,
  input  apu_fs_pkg::sweep_ctrl_t ctrl_i,
  input  wire  [2:0]             shift_i,
  input  wire  [2:0]             period_i,
  input  wire  [10:0]            load_frequency_i,
  output logic [10:0]            frequency_o
);

  logic [10:0] freq_q, freq_d;
  logic [3:0]  cnt_q, cnt_d;
  logic [10:0] delta;
  logic        active;
  logic        fire;
  logic [3:0]  cnt_base;

  // The sweep runs only with a nonzero shift and channel 1 on.
  assign active = ctrl_i.step & ctrl_i.on & (shift_i != 3'd0);
  assign fire = active & (cnt_q >= {1'b0, period_i});
  assign delta = freq_q >> shift_i;
  assign cnt_base = fire ? 4'd0 : cnt_q;

  // Next frequency and counter; the counter advances after every check.
  always_comb begin
    freq_d = freq_q;
    cnt_d = cnt_q;
    if (ctrl_i.load) begin
      freq_d = load_frequency_i;
      cnt_d = 4'd0;
    end else if (active) begin
      cnt_d = cnt_base + 4'd1;
      if (fire) begin
        freq_d = ctrl_i.up ? (freq_q + delta) : (freq_q - delta);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      freq_q <= 11'd0;
      cnt_q <= 4'd0;
    end else begin
      freq_q <= freq_d;
      cnt_q <= cnt_d;
    end
  end

  assign frequency_o = freq_q;

endmodule
`default_nettype wire

@@ hdl/apu_frame_sequencer.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// APU frame sequencer
// Envelope, sweep and length sequencing of a four-channel sound unit.
// ----------------------------------------------------------------------------
// Usage:
//  The input channel (in_valid_i / in_stall_o) takes one item per cycle unless it stalls:
//  either a divider-bit event or a load that restarts one channel.
//  Each item gives exactly one result on the output channel
//  (out_valid_o / out_stall_i): the volumes, channel on mask and channel 1
//  frequency after that item.
//  An accepted item waits in the input register; its state update is
//  committed when it moves on, and the result is valid the cycle after,
//  so one item per cycle passes while the receiver does not stall.
//  The channel state registers double as the result register.
//  While the receiver stalls, the held result stays and the input register
//  keeps one more item; the input channel then stalls as well.
//  Configuration writes (cfg_valid_i / cfg_ready_o) are always taken and
//  belong to idle periods. Reset clears all but the payload registers: all
//  channels off, volumes, counters and frequency zero, no item pending.
// ----------------------------------------------------------------------------
module apu_frame_sequencer (
  input  wire         clk_i,
  input  wire         rst_ni,
  // Input items
  input  wire         in_valid_i,
  output logic        in_stall_o,
  input  wire         action_i,
  input  wire  [3:0]  div_bit_i,
  input  wire  [1:0]  channel_i,
  input  wire  [3:0]  load_volume_i,
  input  wire  [7:0]  load_length_i,
  input  wire  [10:0] load_frequency_i,
  // Result items
  output logic        out_valid_o,
  input  wire         out_stall_i,
  output logic [3:0]  volume_one_o,
  output logic [3:0]  volume_two_o,
  output logic [3:0]  volume_four_o,
  output logic [3:0]  active_mask_o,
  output logic [10:0] sweep_frequency_o,
  // Configuration writes
  input  wire         cfg_valid_i,
  output logic        cfg_ready_o,
  input  wire  [apu_fs_pkg::CfgIdxWidth-1:0]  cfg_index_i,
  input  wire  [apu_fs_pkg::CfgDataWidth-1:0] cfg_data_i
);

  // Configuration registers.
  logic [2:0] env_period_q [3];
  logic [2:0] env_up_q;
  logic [2:0] sweep_shift_q;
  logic [2:0] sweep_period_q;
  logic       sweep_up_q;
  logic [3:0] len_en_q;

  // Input register.
  logic        s1_valid_q;
  logic        s1_action_q;
  logic [3:0]  s1_div_bit_q;
  logic [1:0]  s1_channel_q;
  logic [3:0]  s1_volume_q;
  logic [7:0]  s1_length_q;
  logic [10:0] s1_freq_q;

  // Channel state.
  logic [3:0] on_q, on_d;
  logic [5:0] short_len_q [3];
  logic [5:0] short_len_d [3];
  logic [7:0] wave_len_q, wave_len_d;
  logic       out_valid_q;

  logic       s1_adv;
  logic       in_accept;
  logic       is_load;
  logic       env_tick;
  logic       sweep_tick;
  logic       len_tick;
  logic [2:0] env_off;
  logic [2:0] slot_load;
  logic [3:0] on_env;
  logic [3:0] vol_slot [3];

  apu_fs_pkg::env_ctrl_t   env_ctrl [3];
  apu_fs_pkg::sweep_ctrl_t sweep_ctrl;

  // Channel number of each envelope and short length slot.
  localparam logic [1:0] SlotChan [3] = '{apu_fs_pkg::ChanOne, apu_fs_pkg::ChanTwo,
                                          apu_fs_pkg::ChanFour};

  // Handshakes: the input register moves on when the result slot is free.
  assign cfg_ready_o = 1'b1;
  assign s1_adv = s1_valid_q & (~out_valid_q | ~out_stall_i);
  assign in_stall_o = s1_valid_q & ~s1_adv;
  assign in_accept = in_valid_i & ~in_stall_o;

  // Configuration write decode.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      env_period_q[0] <= 3'd0;
      env_period_q[1] <= 3'd0;
      env_period_q[2] <= 3'd0;
      env_up_q <= 3'd0;
      sweep_shift_q <= 3'd0;
      sweep_period_q <= 3'd0;
      sweep_up_q <= 1'b0;
      len_en_q <= 4'd0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (apu_fs_pkg::cfg_idx_e'(cfg_index_i))
        apu_fs_pkg::CFG_ENV1_PERIOD:  env_period_q[0] <= cfg_data_i[2:0];
        apu_fs_pkg::CFG_ENV2_PERIOD:  env_period_q[1] <= cfg_data_i[2:0];
        apu_fs_pkg::CFG_ENV4_PERIOD:  env_period_q[2] <= cfg_data_i[2:0];
        apu_fs_pkg::CFG_ENV_UP_MASK:  env_up_q <= cfg_data_i[2:0];
        apu_fs_pkg::CFG_SWEEP_SHIFT:  sweep_shift_q <= cfg_data_i[2:0];
        apu_fs_pkg::CFG_SWEEP_PERIOD: sweep_period_q <= cfg_data_i[2:0];
        apu_fs_pkg::CFG_SWEEP_UP:     sweep_up_q <= cfg_data_i[0];
        apu_fs_pkg::CFG_LEN_ENABLE:   len_en_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Input register control.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_accept) begin
      s1_valid_q <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  // Input register payload.
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_action_q <= action_i;
      s1_div_bit_q <= div_bit_i;
      s1_channel_q <= channel_i;
      s1_volume_q <= load_volume_i;
      s1_length_q <= load_length_i;
      s1_freq_q <= load_frequency_i;
    end
  end

  // Decode of the committed item.
  assign is_load = s1_adv & (s1_action_q == apu_fs_pkg::ActionLoad);
  assign env_tick = s1_adv & (s1_action_q == apu_fs_pkg::ActionEvent) &
                    (s1_div_bit_q >= apu_fs_pkg::EnvDivBit);
  assign sweep_tick = s1_adv & (s1_action_q == apu_fs_pkg::ActionEvent) &
                      (s1_div_bit_q >= apu_fs_pkg::SweepDivBit);
  assign len_tick = s1_adv & (s1_action_q == apu_fs_pkg::ActionEvent) &
                    (s1_div_bit_q >= apu_fs_pkg::LengthDivBit);

  // Envelope slots for channels 1, 2 and 4.
  for (genvar s = 0; s < 3; s++) begin : g_env
    assign slot_load[s] = is_load & (s1_channel_q == SlotChan[s]);
    assign env_ctrl[s] = '{step: env_tick, load: slot_load[s],
                           up: env_up_q[s], on: on_q[SlotChan[s]]};

    apu_fs_env u_env (
      .clk_i         (clk_i),
      .rst_ni        (rst_ni),
      .ctrl_i        (env_ctrl[s]),
      .period_i      (env_period_q[s]),
      .load_volume_i (s1_volume_q),
      .volume_o      (vol_slot[s]),
      .off_o         (env_off[s])
    );
  end

  // On flags after the envelope step; the sweep sees this value.
  assign on_env = on_q & ~{env_off[2], 1'b0, env_off[1], env_off[0]};

  assign sweep_ctrl = '{step: sweep_tick,
                        load: is_load & (s1_channel_q == apu_fs_pkg::ChanOne),
                        up: sweep_up_q, on: on_env[0]};

  apu_fs_sweep u_sweep (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .ctrl_i           (sweep_ctrl),
    .shift_i          (sweep_shift_q),
    .period_i         (sweep_period_q),
    .load_frequency_i (s1_freq_q),
    .frequency_o      (sweep_frequency_o)
  );

  // Length counters and channel on flags.
  always_comb begin
    on_d = on_q;
    wave_len_d = wave_len_q;
    for (int s = 0; s < 3; s++) begin
      short_len_d[s] = short_len_q[s];
    end
    if (is_load) begin
      on_d[s1_channel_q] = 1'b1;
      if (s1_channel_q == apu_fs_pkg::ChanThree) begin
        wave_len_d = s1_length_q;
      end
      for (int s = 0; s < 3; s++) begin
        if (slot_load[s]) begin
          short_len_d[s] = s1_length_q[5:0];
        end
      end
    end else begin
      on_d = on_env;
      if (len_tick) begin
        for (int s = 0; s < 3; s++) begin
          if (len_en_q[SlotChan[s]]) begin
            short_len_d[s] = short_len_q[s] + 6'd1;
            if (short_len_d[s] == 6'd0) begin
              on_d[SlotChan[s]] = 1'b0;
            end
          end
        end
        if (len_en_q[apu_fs_pkg::ChanThree]) begin
          wave_len_d = wave_len_q + 8'd1;
          if (wave_len_d == 8'd0) begin
            on_d[apu_fs_pkg::ChanThree] = 1'b0;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      on_q <= 4'd0;
      wave_len_q <= 8'd0;
      short_len_q[0] <= 6'd0;
      short_len_q[1] <= 6'd0;
      short_len_q[2] <= 6'd0;
      out_valid_q <= 1'b0;
    end else begin
      on_q <= on_d;
      wave_len_q <= wave_len_d;
      short_len_q[0] <= short_len_d[0];
      short_len_q[1] <= short_len_d[1];
      short_len_q[2] <= short_len_d[2];
      if (s1_adv) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Results come straight from the channel state.
  assign out_valid_o = out_valid_q;
  assign volume_one_o = vol_slot[0];
  assign volume_two_o = vol_slot[1];
  assign volume_four_o = vol_slot[2];
  assign active_mask_o = on_q;

`ifndef ASSERT_OFF
  // The input side stalls only while an item waits in the input register.
  a_stall_needs_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> s1_valid_q)
    else $error("input stalled with empty input register");

  // A load always leaves its channel on.
  a_load_turns_on: assert property (@(posedge clk_i) disable iff (!rst_ni)
    is_load |=> on_q[$past(s1_channel_q)])
    else $error("loaded channel is not on");

  // The channel state only changes when an item is committed.
  a_state_on_commit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s1_adv |=> $stable(sweep_frequency_o) && $stable(on_q) &&
                $stable(volume_one_o))
    else $error("channel state changed without an item");

  // A new result appears only after a commit.
  a_result_from_commit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(s1_adv))
    else $error("result without committed item");
`endif

endmodule
`default_nettype wire

@@ sim/apu_frame_sequencer_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// APU frame sequencer testbench
// Drives divider events and channel loads into the sequencer and checks the
// volumes, channel on mask and channel 1 frequency that come back after
// every item. A short table of directed items runs first; random items under
// several register settings follow. Both sides idle and stall at random.
// ----------------------------------------------------------------------------
module apu_frame_sequencer_tb;

  localparam int ClkPeriod = 10;
  localparam int ResetCycles = 3;
  localparam int SettleCycles = 4;
  localparam int HoldCycles = 60;
  localparam int StallLimit = 1000;
  localparam int NumBlocks = 7;
  localparam int ItemsPerBlock = 66;
  localparam int HoldBlock = 5;
  localparam int NumRows = 33;

  // One input item and one result item, at the port widths.
  typedef struct packed {
    logic        action;
    logic [3:0]  div_bit;
    logic [1:0]  channel;
    logic [3:0]  load_volume;
    logic [7:0]  load_length;
    logic [10:0] load_frequency;
  } frame_item_t;

  typedef struct packed {
    logic [3:0]  volume_one;
    logic [3:0]  volume_two;
    logic [3:0]  volume_four;
    logic [3:0]  active_mask;
    logic [10:0] sweep_frequency;
  } frame_status_t;

  // Rows of the directed plan: an item, an item with a hand-written result,
  // or a register write.
  typedef enum logic [1:0] {
    ROW_ITEM,
    ROW_KNOWN,
    ROW_REG
  } row_kind_e;

  typedef struct packed {
    row_kind_e            kind;
    apu_fs_pkg::cfg_idx_e reg_idx;
    logic [3:0]           reg_val;
    frame_item_t          item;
    frame_status_t        status;
  } plan_row_t;

  // Ports of the block.
  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic        action_i = 1'b0;
  logic [3:0]  div_bit_i = '0;
  logic [1:0]  channel_i = '0;
  logic [3:0]  load_volume_i = '0;
  logic [7:0]  load_length_i = '0;
  logic [10:0] load_frequency_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [3:0]  volume_one_o;
  logic [3:0]  volume_two_o;
  logic [3:0]  volume_four_o;
  logic [3:0]  active_mask_o;
  logic [10:0] sweep_frequency_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [apu_fs_pkg::CfgIdxWidth-1:0]  cfg_index_i = '0;
  logic [apu_fs_pkg::CfgDataWidth-1:0] cfg_data_i = '0;

  // Hand-written result that travels with the item on offer, if any.
  logic          item_known = 1'b0;
  frame_status_t item_status = '0;

  // Idling control of the sender and the receiver.
  int   src_idle_pct = 0;
  int   sink_stall_pct = 0;
  logic hold_request = 1'b0;

  int fail_count = 0;
  int items_taken = 0;
  int loads_taken = 0;
  int results_seen = 0;
  int reg_writes = 0;

  plan_row_t     directed_plan [NumRows];
  frame_status_t channel_status_q [$];

  // Predicted sequencer state; slots 0, 1, 2 are channels 1, 2, 4.
  logic [3:0]  env_volume [3] = '{default: '0};
  logic [2:0]  env_count [3] = '{default: '0};
  logic [3:0]  sweep_count = '0;
  logic [10:0] chan_freq = '0;
  logic [5:0]  short_len [3] = '{default: '0};
  logic [7:0]  wave_len = '0;
  logic [3:0]  chan_on = '0;

  // Predicted register contents.
  logic [2:0] env_period [3] = '{default: '0};
  logic [2:0] env_rise = '0;
  logic [2:0] sw_shift = '0;
  logic [2:0] sw_period = '0;
  logic       sw_rise = 1'b0;
  logic [3:0] len_enable = '0;

  wire in_fire = in_valid_i && !in_stall_o;
  wire out_fire = out_valid_o && !out_stall_i;
  wire cfg_fire = cfg_valid_i && cfg_ready_o;

  apu_frame_sequencer dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .action_i          (action_i),
    .div_bit_i         (div_bit_i),
    .channel_i         (channel_i),
    .load_volume_i     (load_volume_i),
    .load_length_i     (load_length_i),
    .load_frequency_i  (load_frequency_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .volume_one_o      (volume_one_o),
    .volume_two_o      (volume_two_o),
    .volume_four_o     (volume_four_o),
    .active_mask_o     (active_mask_o),
    .sweep_frequency_o (sweep_frequency_o),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_ready_o       (cfg_ready_o),
    .cfg_index_i       (cfg_index_i),
    .cfg_data_i        (cfg_data_i)
  );

  always #(ClkPeriod / 2) clk_i = ~clk_i;

  // Register write as the block sees it; 3-bit registers drop the top bit.
  function automatic void apply_register(logic [apu_fs_pkg::CfgIdxWidth-1:0] index,
                                         logic [apu_fs_pkg::CfgDataWidth-1:0] data);
    case (apu_fs_pkg::cfg_idx_e'(index))
      apu_fs_pkg::CFG_ENV1_PERIOD:  env_period[0] = data[2:0];
      apu_fs_pkg::CFG_ENV2_PERIOD:  env_period[1] = data[2:0];
      apu_fs_pkg::CFG_ENV4_PERIOD:  env_period[2] = data[2:0];
      apu_fs_pkg::CFG_ENV_UP_MASK:  env_rise = data[2:0];
      apu_fs_pkg::CFG_SWEEP_SHIFT:  sw_shift = data[2:0];
      apu_fs_pkg::CFG_SWEEP_PERIOD: sw_period = data[2:0];
      apu_fs_pkg::CFG_SWEEP_UP:     sw_rise = data[0];
      apu_fs_pkg::CFG_LEN_ENABLE:   len_enable = data[3:0];
      default: ;
    endcase
  endfunction

  // One envelope tick of a slot. Going down, the channel goes off at zero.
  function automatic void clock_envelope(int slot);
    int chan;
    chan = (slot == 2) ? 3 : slot;
    if (env_period[slot] == 3'd0 || !chan_on[chan]) return;
    env_count[slot] = env_count[slot] + 3'd1;
    if (env_count[slot] >= env_period[slot]) begin
      env_count[slot] = '0;
      if (env_rise[slot]) begin
        if (env_volume[slot] != apu_fs_pkg::VolMax) begin
          env_volume[slot] = env_volume[slot] + 4'd1;
        end
      end else begin
        if (env_volume[slot] != 4'd0) env_volume[slot] = env_volume[slot] - 4'd1;
        if (env_volume[slot] == 4'd0) chan_on[chan] = 1'b0;
      end
    end
  endfunction

  // Updates the predicted state for one item and returns the status after it.
  function automatic frame_status_t apply_frame_item(frame_item_t it);
    int          slot;
    int          chan;
    logic [10:0] delta;
    if (it.action == apu_fs_pkg::ActionLoad) begin
      chan_on[it.channel] = 1'b1;
      if (it.channel == apu_fs_pkg::ChanThree) begin
        wave_len = it.load_length;
      end else begin
        slot = (it.channel == apu_fs_pkg::ChanFour) ? 2 : int'(it.channel);
        env_volume[slot] = it.load_volume;
        env_count[slot] = '0;
        short_len[slot] = it.load_length[5:0];
        if (it.channel == apu_fs_pkg::ChanOne) begin
          chan_freq = it.load_frequency;
          sweep_count = '0;
        end
      end
    end else begin
      // All three units step on bit 15, sweep and length also on bit 14, length also on bit 13.
      if (it.div_bit >= apu_fs_pkg::EnvDivBit) begin
        for (int s = 0; s < 3; s++) clock_envelope(s);
      end
      if (it.div_bit >= apu_fs_pkg::SweepDivBit && sw_shift != 3'd0 && chan_on[0]) begin
        if (sweep_count >= {1'b0, sw_period}) begin
          sweep_count = '0;
          delta = chan_freq >> sw_shift;
          chan_freq = sw_rise ? chan_freq + delta : chan_freq - delta;
        end
        sweep_count = sweep_count + 4'd1;
      end
      if (it.div_bit >= apu_fs_pkg::LengthDivBit) begin
        for (int s = 0; s < 3; s++) begin
          chan = (s == 2) ? 3 : s;
          if (len_enable[chan]) begin
            short_len[s] = short_len[s] + 6'd1;
            if (short_len[s] == 6'd0) chan_on[chan] = 1'b0;
          end
        end
        if (len_enable[2]) begin
          wave_len = wave_len + 8'd1;
          if (wave_len == 8'd0) chan_on[2] = 1'b0;
        end
      end
    end
    return {env_volume[0], env_volume[1], env_volume[2], chan_on, chan_freq};
  endfunction

  // Events carry all-ones load fields, which the block must ignore.
  function automatic plan_row_t divider_row(logic [3:0] div);
    plan_row_t row;
    row = '0;
    row.kind = ROW_ITEM;
    row.item = {apu_fs_pkg::ActionEvent, div, apu_fs_pkg::ChanFour, 4'hF, 8'hFF,
                11'h7FF};
    return row;
  endfunction

  // Loads carry divider bit 15, which the block must ignore.
  function automatic plan_row_t load_row(logic [1:0] chan, logic [3:0] vol,
                                         logic [7:0] len, logic [10:0] freq);
    plan_row_t row;
    row = '0;
    row.kind = ROW_ITEM;
    row.item = {apu_fs_pkg::ActionLoad, apu_fs_pkg::EnvDivBit, chan, vol, len, freq};
    return row;
  endfunction

  function automatic plan_row_t register_row(apu_fs_pkg::cfg_idx_e idx, logic [3:0] val);
    plan_row_t row;
    row = '0;
    row.kind = ROW_REG;
    row.reg_idx = idx;
    row.reg_val = val;
    return row;
  endfunction

  function automatic plan_row_t with_status(plan_row_t row, frame_status_t st);
    row.kind = ROW_KNOWN;
    row.status = st;
    return row;
  endfunction

  // Mostly loads and events on the top three divider bits, some noise events.
  function automatic frame_item_t random_item();
    logic [31:0] bits;
    frame_item_t it;
    int          pick;
    bits = $urandom;
    it = bits[29:0];
    pick = $urandom_range(99);
    if (pick < 20) begin
      it.action = apu_fs_pkg::ActionLoad;
      // Lengths close to the wrap point, so channels run out soon.
      if ($urandom_range(9) < 4) it.load_length[7:3] = '1;
    end else if (pick < 85) begin
      it.action = apu_fs_pkg::ActionEvent;
      it.div_bit = 4'($urandom_range(15, 13));
    end else begin
      it.action = apu_fs_pkg::ActionEvent;
    end
    return it;
  endfunction

  task automatic check_field(string name, logic [10:0] want, logic [10:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endtask

  // Offers one item after a random idle stretch and waits until it is taken.
  task automatic offer_item(frame_item_t it, logic known, frame_status_t st);
    while ($urandom_range(99) < src_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    {action_i, div_bit_i, channel_i, load_volume_i, load_length_i,
     load_frequency_i} <= it;
    item_known <= known;
    item_status <= st;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  // Stops offering and waits until every result is back and the block is idle.
  task automatic settle_block();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (channel_status_q.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_register(apu_fs_pkg::cfg_idx_e idx, logic [3:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Checks each result against the oldest expectation and predicts new items.
  always @(posedge clk_i) begin : scoreboard
    frame_status_t seen;
    frame_status_t want;
    frame_status_t predicted;
    if (rst_ni) begin
      if (out_fire) begin
        results_seen++;
        seen = {volume_one_o, volume_two_o, volume_four_o, active_mask_o,
                sweep_frequency_o};
        if (channel_status_q.size() == 0) begin
          $error("result with no item outstanding");
          fail_count++;
        end else begin
          want = channel_status_q.pop_front();
          check_field("volume_one", 11'(want.volume_one), 11'(seen.volume_one));
          check_field("volume_two", 11'(want.volume_two), 11'(seen.volume_two));
          check_field("volume_four", 11'(want.volume_four), 11'(seen.volume_four));
          check_field("active_mask", 11'(want.active_mask), 11'(seen.active_mask));
          check_field("sweep_frequency", want.sweep_frequency,
                      seen.sweep_frequency);
        end
      end
      if (in_fire) begin
        items_taken++;
        if (action_i == apu_fs_pkg::ActionLoad) loads_taken++;
        predicted = apply_frame_item({action_i, div_bit_i, channel_i, load_volume_i,
                                      load_length_i, load_frequency_i});
        channel_status_q.push_back(item_known ? item_status : predicted);
      end
      if (cfg_fire) begin
        reg_writes++;
        apply_register(cfg_index_i, cfg_data_i);
      end
    end
  end

  // Receiver: random stalls, plus one long hold-off on request.
  initial begin : result_sink
    forever begin
      @(posedge clk_i);
      if (hold_request) begin
        hold_request = 1'b0;
        out_stall_i <= 1'b1;
        repeat (HoldCycles) @(posedge clk_i);
      end
      out_stall_i <= ($urandom_range(99) < sink_stall_pct);
    end
  end

  // Ends the run when nothing moves on any channel for too long.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < StallLimit) begin
      @(posedge clk_i);
      if (in_fire || out_fire || cfg_fire) quiet = 0;
      else quiet++;
    end
    $display("Timeout: nothing moved for %0d cycles.", StallLimit);
    $display("apu_frame_sequencer_tb failed");
    $finish;
  end

  initial begin : stimulus
    frame_item_t          it;
    int                   useful;
    int                   blk;
    logic [3:0]           setting [8];
    apu_fs_pkg::cfg_idx_e idx;

    // Values right after reset and at the field extremes are written out;
    // the rest is left to the prediction.
    directed_plan = '{
      with_status(divider_row(4'd0), {4'd0, 4'd0, 4'd0, 4'd0, 11'd0}),
      with_status(divider_row(4'd15), {4'd0, 4'd0, 4'd0, 4'd0, 11'd0}),
      with_status(load_row(apu_fs_pkg::ChanOne, 4'd15, 8'hFF, 11'd2047),
                  {4'd15, 4'd0, 4'd0, 4'h1, 11'd2047}),
      with_status(load_row(apu_fs_pkg::ChanTwo, 4'd0, 8'd0, 11'd2047),
                  {4'd15, 4'd0, 4'd0, 4'h3, 11'd2047}),
      with_status(load_row(apu_fs_pkg::ChanThree, 4'd15, 8'hFF, 11'd0),
                  {4'd15, 4'd0, 4'd0, 4'h7, 11'd2047}),
      with_status(load_row(apu_fs_pkg::ChanFour, 4'd15, 8'd63, 11'd0),
                  {4'd15, 4'd0, 4'd15, 4'hF, 11'd2047}),
      // All registers still zero: no unit moves.
      with_status(divider_row(4'd15), {4'd15, 4'd0, 4'd15, 4'hF, 11'd2047}),
      register_row(apu_fs_pkg::CFG_ENV1_PERIOD, 4'd1),
      register_row(apu_fs_pkg::CFG_ENV2_PERIOD, 4'd1),
      register_row(apu_fs_pkg::CFG_ENV4_PERIOD, 4'd7),
      register_row(apu_fs_pkg::CFG_ENV_UP_MASK, 4'd1),
      register_row(apu_fs_pkg::CFG_SWEEP_SHIFT, 4'd1),
      register_row(apu_fs_pkg::CFG_SWEEP_PERIOD, 4'd0),
      register_row(apu_fs_pkg::CFG_SWEEP_UP, 4'd0),
      register_row(apu_fs_pkg::CFG_LEN_ENABLE, 4'd15),
      // Low divider bit, then volume at the top, volume to zero, lengths wrap.
      divider_row(4'd12),
      divider_row(4'd15),
      load_row(apu_fs_pkg::ChanOne, 4'd14, 8'd62, 11'd1),
      divider_row(4'd14),
      divider_row(4'd13),
      divider_row(4'd15),
      load_row(apu_fs_pkg::ChanFour, 4'd1, 8'd0, 11'd0),
      // Upward sweep that overflows the 11-bit frequency.
      register_row(apu_fs_pkg::CFG_SWEEP_UP, 4'd1),
      register_row(apu_fs_pkg::CFG_SWEEP_SHIFT, 4'd7),
      load_row(apu_fs_pkg::ChanOne, 4'd0, 8'd0, 11'd2047),
      divider_row(4'd14),
      // Channel 4 steps down at its longest period and turns off.
      divider_row(4'd15),
      divider_row(4'd15),
      divider_row(4'd15),
      divider_row(4'd15),
      divider_row(4'd15),
      divider_row(4'd15),
      divider_row(4'd15)
    };

    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    src_idle_pct = 34;
    sink_stall_pct = 64;
    foreach (directed_plan[r]) begin
      if (directed_plan[r].kind == ROW_REG) begin
        settle_block();
        write_register(directed_plan[r].reg_idx, directed_plan[r].reg_val);
      end else begin
        offer_item(directed_plan[r].item, directed_plan[r].kind == ROW_KNOWN,
                   directed_plan[r].status);
      end
    end

    // Random blocks, each under its own register setting.
    for (blk = 0; blk < NumBlocks; blk++) begin
      if (blk < 3) begin
        src_idle_pct = 34;
        sink_stall_pct = 64;
      end else if (blk < HoldBlock) begin
        src_idle_pct = 64;
        sink_stall_pct = 34;
      end else begin
        src_idle_pct = 0;
        sink_stall_pct = 0;
      end
      settle_block();
      case (blk)
        0: setting = '{default: 4'hF};
        1: setting = '{4'd1, 4'd2, 4'd3, 4'd2, 4'd1, 4'd0, 4'd0, 4'd15};
        2: setting = '{default: 4'h0};
        default: begin
          foreach (setting[k]) setting[k] = 4'($urandom_range(15));
        end
      endcase
      idx = idx.first();
      do begin
        write_register(idx, setting[idx]);
        idx = idx.next();
      end while (idx != idx.first());
      if (blk == HoldBlock) hold_request = 1'b1;
      useful = 0;
      while (useful < ItemsPerBlock) begin
        it = random_item();
        offer_item(it, 1'b0, '0);
        if (it.action == apu_fs_pkg::ActionLoad ||
            it.div_bit >= apu_fs_pkg::LengthDivBit) useful++;
      end
    end

    settle_block();
    $display("Covered %0d items (%0d channel loads), %0d results, %0d register writes.",
             items_taken, loads_taken, results_seen, reg_writes);
    $display("Idling alternated between sender and receiver, with one long result hold-off.");
    if (fail_count == 0) begin
      $display("apu_frame_sequencer_tb passed");
    end else begin
      $display("apu_frame_sequencer_tb failed");
    end
    $finish;
  end

endmodule
